@@ rtl/segment_segment_distance_macros.svh @@
// Assertion helpers for the segment distance block.
`ifndef SEGMENT_SEGMENT_DISTANCE_MACROS_SVH
`define SEGMENT_SEGMENT_DISTANCE_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define SSD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held.
`define SSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ssd_pkg.sv @@
package ssd_pkg;

    localparam int COORD_BITS_DEF = 24;
    // Segment parameters are Q1.16
    localparam int SC_BITS        = 16;
    localparam int QUEUE_DEPTH    = 4;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

@@ rtl/ssd_mul.sv @@
module ssd_mul #(
    parameter int W = 52
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [W-1:0]   i_a,
    input  logic signed [W-1:0]   i_b,
    output logic signed [2*W-1:0] o_p
);
    import ssd_pkg::*;

    localparam int H = (W + 1) / 2;

    logic [W-1:0]   mag_a;
    logic [W-1:0]   mag_b;
    logic [2*H-1:0] ext_a;
    logic [2*H-1:0] ext_b;
    logic [2*H-1:0] r_ll;
    logic [2*H-1:0] r_lh;
    logic [2*H-1:0] r_hl;
    logic [2*H-1:0] r_hh;
    logic           r_neg;
    logic [4*H-1:0] sum;
    logic [2*W-1:0] prod;

    // sign-magnitude split into four half-width partial products
    assign mag_a = i_a[W-1] ? (W'(0) - $unsigned(i_a)) : $unsigned(i_a);
    assign mag_b = i_b[W-1] ? (W'(0) - $unsigned(i_b)) : $unsigned(i_b);
    assign ext_a = (2*H)'(mag_a);
    assign ext_b = (2*H)'(mag_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll  <= ext_a[H-1:0] * ext_b[H-1:0];
            r_lh  <= ext_a[H-1:0] * ext_b[2*H-1:H];
            r_hl  <= ext_a[2*H-1:H] * ext_b[H-1:0];
            r_hh  <= ext_a[2*H-1:H] * ext_b[2*H-1:H];
            r_neg <= i_a[W-1] ^ i_b[W-1];
        end
    end

    assign sum = ((4*H)'(r_hh) << (2*H)) + ((4*H)'(r_lh) << H)
               + ((4*H)'(r_hl) << H) + (4*H)'(r_ll);
    assign prod = sum[2*W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_p <= r_neg ? $signed((2*W)'(0) - prod) : $signed(prod);
        end
    end

endmodule

@@ rtl/ssd_fifo.sv @@
module ssd_fifo #(
    parameter int W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [W-1:0]     i_data,
    output ssd_pkg::t_q_stat o_stat,
    output logic             o_vld,
    output logic [W-1:0]     o_data
);
    import ssd_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]  r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [NW-1:0] r_cnt;
    logic          pop;

    // back end never stalls: drain whenever something is queued
    assign pop = (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (pop) begin
            o_data <= r_mem[r_rp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
            o_vld <= 1'b0;
        end else begin
            o_vld <= pop;
            if (i_push) begin
                r_wp <= (r_wp == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            r_cnt <= r_cnt + NW'(i_push) - NW'(pop);
        end
    end

    assign o_stat.full  = (r_cnt == NW'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

@@ rtl/ssd_front.sv @@
module ssd_front #(
    parameter int  COORD_BITS = 24,
    localparam int VW = COORD_BITS + 1,
    localparam int DW = 2 * VW + 2,
    localparam int NW = 2 * DW + 1,
    localparam int JW = 4 * NW + 9 * VW
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic [12*COORD_BITS-1:0] i_coords,
    input  ssd_pkg::t_q_stat        i_q_stat,
    output logic                    o_stall,
    output logic                    o_push,
    output logic [JW-1:0]           o_job
);
    import ssd_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int NST = 10;

    logic                   en;
    logic [NST-1:0]         r_vld;
    logic [12*CB-1:0]       r_crd;
    logic signed [CB-1:0]   c_in [12];
    logic [9*VW-1:0]        n_vec;
    logic [9*VW-1:0]        r_vec [1:9];
    logic signed [VW-1:0]   s_u [3];
    logic signed [VW-1:0]   s_v [3];
    logic signed [VW-1:0]   s_w [3];
    logic signed [2*VW-1:0] r_pr [5][3];
    logic signed [DW-1:0]   r_dot [3:8][5];
    logic signed [2*DW-1:0] p_ac, p_bb, p_be, p_cd, p_ae, p_bd;
    logic signed [NW-1:0]   r_det, r_snr, r_tnr;
    logic signed [NW-1:0]   n_sn7, n_sd7, n_tn7, n_td7;
    logic signed [NW-1:0]   r_sn7, r_sd7, r_tn7, r_td7;
    logic signed [NW-1:0]   n_tn8, n_t8;
    logic                   n_fix8;
    logic signed [NW-1:0]   r_sn8, r_sd8, r_tn8, r_td8, r_t8;
    logic                   r_fix8;
    logic signed [NW-1:0]   n_sn9, n_sd9;
    logic signed [NW-1:0]   r_sn9, r_sd9, r_tn9, r_td9;
    logic signed [NW-1:0]   b6, c6, e6, b8, d8, a9;

    // hold the whole pipe when the queue cannot take the finished item
    assign en      = !(r_vld[NST-1] && i_q_stat.full);
    assign o_stall = !en;
    assign o_push  = r_vld[NST-1] && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_accept};
        end
    end

    // u = A end - A start, v = B end - B start, w = A start - B start
    always_comb begin
        for (int n = 0; n < 12; n++) begin
            c_in[n] = $signed(r_crd[n*CB +: CB]);
        end
        for (int i = 0; i < 3; i++) begin
            n_vec[i*VW +: VW]     = VW'(c_in[3+i]) - VW'(c_in[i]);
            n_vec[(3+i)*VW +: VW] = VW'(c_in[9+i]) - VW'(c_in[6+i]);
            n_vec[(6+i)*VW +: VW] = VW'(c_in[i]) - VW'(c_in[6+i]);
        end
        for (int i = 0; i < 3; i++) begin
            s_u[i] = $signed(r_vec[1][i*VW +: VW]);
            s_v[i] = $signed(r_vec[1][(3+i)*VW +: VW]);
            s_w[i] = $signed(r_vec[1][(6+i)*VW +: VW]);
        end
    end

    // a..e products and sums
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_crd   <= i_coords;
            r_vec[1] <= n_vec;
            for (int k = 2; k <= 9; k++) begin
                r_vec[k] <= r_vec[k-1];
            end
            for (int i = 0; i < 3; i++) begin
                r_pr[0][i] <= s_u[i] * s_u[i];
                r_pr[1][i] <= s_u[i] * s_v[i];
                r_pr[2][i] <= s_v[i] * s_v[i];
                r_pr[3][i] <= s_u[i] * s_w[i];
                r_pr[4][i] <= s_v[i] * s_w[i];
            end
            for (int k = 0; k < 5; k++) begin
                r_dot[3][k] <= DW'(r_pr[k][0]) + DW'(r_pr[k][1]) + DW'(r_pr[k][2]);
            end
            for (int s = 4; s <= 8; s++) begin
                r_dot[s] <= r_dot[s-1];
            end
        end
    end

    // dot order: a=0 b=1 c=2 d=3 e=4
    ssd_mul #(.W(DW)) u_mul_ac (.i_clk(i_clk), .i_en(en), .i_a(r_dot[3][0]),
                               .i_b(r_dot[3][2]), .o_p(p_ac));
    ssd_mul #(.W(DW)) u_mul_bb (.i_clk(i_clk), .i_en(en), .i_a(r_dot[3][1]),
                               .i_b(r_dot[3][1]), .o_p(p_bb));
    ssd_mul #(.W(DW)) u_mul_be (.i_clk(i_clk), .i_en(en), .i_a(r_dot[3][1]),
                               .i_b(r_dot[3][4]), .o_p(p_be));
    ssd_mul #(.W(DW)) u_mul_cd (.i_clk(i_clk), .i_en(en), .i_a(r_dot[3][2]),
                               .i_b(r_dot[3][3]), .o_p(p_cd));
    ssd_mul #(.W(DW)) u_mul_ae (.i_clk(i_clk), .i_en(en), .i_a(r_dot[3][0]),
                               .i_b(r_dot[3][4]), .o_p(p_ae));
    ssd_mul #(.W(DW)) u_mul_bd (.i_clk(i_clk), .i_en(en), .i_a(r_dot[3][1]),
                               .i_b(r_dot[3][3]), .o_p(p_bd));

    assign b6 = NW'(r_dot[6][1]);
    assign c6 = NW'(r_dot[6][2]);
    assign e6 = NW'(r_dot[6][4]);
    assign b8 = NW'(r_dot[7][1]);
    assign d8 = NW'(r_dot[7][3]);
    assign a9 = NW'(r_dot[8][0]);

    // first clamp of sc; parallel segments start at sc = 0 / 1
    always_comb begin
        n_sn7 = r_snr;
        n_sd7 = r_det;
        n_tn7 = r_tnr;
        n_td7 = r_det;
        if (r_det <= 0) begin
            n_sn7 = '0;
            n_sd7 = NW'(1);
            n_tn7 = e6;
            n_td7 = c6;
        end else if (r_snr < 0) begin
            n_sn7 = '0;
            n_tn7 = e6;
            n_td7 = c6;
        end else if (r_snr > r_det) begin
            n_sn7 = r_det;
            n_tn7 = e6 + b6;
            n_td7 = c6;
        end
    end

    // clamp tc, pick the recomputed sc numerator
    always_comb begin
        n_tn8  = r_tn7;
        n_t8   = -d8;
        n_fix8 = 1'b0;
        if (r_tn7 < 0) begin
            n_tn8  = '0;
            n_fix8 = 1'b1;
        end else if (r_tn7 > r_td7) begin
            n_tn8  = r_td7;
            n_t8   = -d8 + b8;
            n_fix8 = 1'b1;
        end
    end

    // re-clamp sc after a tc clamp
    always_comb begin
        n_sn9 = r_sn8;
        n_sd9 = r_sd8;
        if (r_fix8) begin
            if (r_t8 < 0) begin
                n_sn9 = '0;
            end else if (r_t8 > a9) begin
                n_sn9 = r_sd8;
            end else begin
                n_sn9 = r_t8;
                n_sd9 = a9;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_det  <= NW'(p_ac) - NW'(p_bb);
            r_snr  <= NW'(p_be) - NW'(p_cd);
            r_tnr  <= NW'(p_ae) - NW'(p_bd);
            r_sn7  <= n_sn7;
            r_sd7  <= n_sd7;
            r_tn7  <= n_tn7;
            r_td7  <= n_td7;
            r_sn8  <= r_sn7;
            r_sd8  <= r_sd7;
            r_tn8  <= n_tn8;
            r_td8  <= r_td7;
            r_t8   <= n_t8;
            r_fix8 <= n_fix8;
            r_sn9  <= n_sn9;
            r_sd9  <= n_sd9;
            r_tn9  <= r_tn8;
            r_td9  <= r_td8;
        end
    end

    assign o_job = {r_sn9, r_sd9, r_tn9, r_td9, r_vec[9]};

endmodule

@@ rtl/ssd_back.sv @@
module ssd_back #(
    parameter int  COORD_BITS = 24,
    localparam int VW = COORD_BITS + 1,
    localparam int DW = 2 * VW + 2,
    localparam int NW = 2 * DW + 1,
    localparam int JW = 4 * NW + 9 * VW
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_vld,
    input  logic [JW-1:0]         i_job,
    output logic                  o_done,
    output logic [COORD_BITS:0]   o_dist
);
    import ssd_pkg::*;

    localparam int RW  = NW + 1;
    localparam int QW  = SC_BITS + 1;
    localparam int PW  = VW + SC_BITS + 2;
    localparam int CW  = VW + SC_BITS + 3;
    localparam int SQW = 2 * CW;
    localparam int RTW = CW;
    localparam int OW  = COORD_BITS + 1;

    // division pipe, lane 0 = sc, lane 1 = tc
    logic signed [NW-1:0] j_num [2];
    logic signed [NW-1:0] j_den [2];
    logic [SC_BITS:0]     r_dv;
    logic [RW-1:0]        r_rem [0:SC_BITS][2];
    logic [RW-1:0]        r_den [0:SC_BITS][2];
    logic [SC_BITS-1:0]   r_qb  [0:SC_BITS][2];
    logic [1:0]           r_fl  [0:SC_BITS][2];
    logic [9*VW-1:0]      r_vec [0:SC_BITS];
    logic [RW-1:0]        rem2  [1:SC_BITS][2];
    logic                 n_ge  [1:SC_BITS][2];
    logic [RW-1:0]        n_rem [1:SC_BITS][2];
    logic [QW-1:0]        q     [2];

    logic                 r_v1, r_v2;
    logic signed [PW-1:0] r_us [3];
    logic signed [PW-1:0] r_vt [3];
    logic signed [VW-1:0] r_w1 [3];
    logic signed [CW-1:0] r_comp [3];
    logic [1:0]           r_vm;
    logic signed [2*CW-1:0] p_sq [3];

    logic [RTW:0]         r_sv;
    logic [SQW-1:0]       r_sr [0:RTW];
    logic [RTW-1:0]       r_rt [0:RTW];
    logic [SQW-1:0]       trial [1:RTW];
    logic                 s_ge  [1:RTW];

    logic [RTW-OW-SC_BITS-1:0] hi_bits;

    assign j_num[0] = $signed(i_job[9*VW+3*NW +: NW]);
    assign j_den[0] = $signed(i_job[9*VW+2*NW +: NW]);
    assign j_num[1] = $signed(i_job[9*VW+NW +: NW]);
    assign j_den[1] = $signed(i_job[9*VW +: NW]);

    // restoring division, one quotient bit per stage
    always_comb begin
        for (int k = 1; k <= SC_BITS; k++) begin
            for (int j = 0; j < 2; j++) begin
                rem2[k][j]  = {r_rem[k-1][j][RW-2:0], 1'b0};
                n_ge[k][j]  = (rem2[k][j] >= r_den[k-1][j]);
                n_rem[k][j] = n_ge[k][j] ? rem2[k][j] - r_den[k-1][j] : rem2[k][j];
            end
        end
        // fl[1]: non-positive operand gives 0, fl[0]: num >= den saturates to 1.0
        for (int j = 0; j < 2; j++) begin
            if (r_fl[SC_BITS][j][1]) begin
                q[j] = '0;
            end else if (r_fl[SC_BITS][j][0]) begin
                q[j] = QW'(1) << SC_BITS;
            end else begin
                q[j] = {1'b0, r_qb[SC_BITS][j]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 2; j++) begin
            r_rem[0][j] <= RW'(j_num[j]);
            r_den[0][j] <= RW'(j_den[j]);
            r_qb[0][j]  <= '0;
            r_fl[0][j]  <= {(j_num[j] <= 0) || (j_den[j] <= 0), j_num[j] >= j_den[j]};
        end
        r_vec[0] <= i_job[9*VW-1:0];
        for (int k = 1; k <= SC_BITS; k++) begin
            for (int j = 0; j < 2; j++) begin
                r_rem[k][j] <= n_rem[k][j];
                r_den[k][j] <= r_den[k-1][j];
                r_qb[k][j]  <= {r_qb[k-1][j][SC_BITS-2:0], n_ge[k][j]};
                r_fl[k][j]  <= r_fl[k-1][j];
            end
            r_vec[k] <= r_vec[k-1];
        end
        // closest vector: w + u*sc - v*tc in Q.16
        for (int i = 0; i < 3; i++) begin
            r_us[i] <= $signed(r_vec[SC_BITS][i*VW +: VW]) * $signed({1'b0, q[0]});
            r_vt[i] <= $signed(r_vec[SC_BITS][(3+i)*VW +: VW]) * $signed({1'b0, q[1]});
            r_w1[i] <= $signed(r_vec[SC_BITS][(6+i)*VW +: VW]);
            r_comp[i] <= (CW'(r_w1[i]) <<< SC_BITS) + CW'(r_us[i]) - CW'(r_vt[i]);
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_sq
        ssd_mul #(.W(CW)) u_mul_sq (
            .i_clk (i_clk),
            .i_en  (1'b1),
            .i_a   (r_comp[i]),
            .i_b   (r_comp[i]),
            .o_p   (p_sq[i])
        );
    end

    // integer square root, one root bit per stage; rem = sum - root^2
    always_comb begin
        for (int s = 1; s <= RTW; s++) begin
            trial[s] = (SQW'(r_rt[s-1]) << (RTW - s + 1)) + (SQW'(1) << (2 * (RTW - s)));
            s_ge[s]  = (r_sr[s-1] >= trial[s]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sr[0] <= $unsigned(p_sq[0]) + $unsigned(p_sq[1]) + $unsigned(p_sq[2]);
        r_rt[0] <= '0;
        for (int s = 1; s <= RTW; s++) begin
            r_sr[s] <= s_ge[s] ? r_sr[s-1] - trial[s] : r_sr[s-1];
            r_rt[s] <= s_ge[s] ? r_rt[s-1] | (RTW'(1) << (RTW - s)) : r_rt[s-1];
        end
    end

    assign hi_bits = r_rt[RTW][RTW-1 : OW+SC_BITS];

    always_ff @(posedge i_clk) begin
        o_dist <= (hi_bits != '0) ? {OW{1'b1}} : r_rt[RTW][SC_BITS +: OW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv   <= '0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_vm   <= '0;
            r_sv   <= '0;
            o_done <= 1'b0;
        end else begin
            r_dv   <= {r_dv[SC_BITS-1:0], i_vld};
            r_v1   <= r_dv[SC_BITS];
            r_v2   <= r_v1;
            r_vm   <= {r_vm[0], r_v2};
            r_sv   <= {r_sv[RTW-1:0], r_vm[1]};
            o_done <= r_sv[RTW];
        end
    end

endmodule

@@ rtl/segment_segment_distance.sv @@
// Throughput: one item per cycle; busy rises only if the queue fills.
// Reset: i_rst_n synchronous, active low; clears valid bits and queue pointers.
// o_done pulses for one cycle per item and the receiver cannot stall it.
`include "segment_segment_distance_macros.svh"

module segment_segment_distance #(
    parameter int COORD_BITS = ssd_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] i_seg_a_start_x,
    input  logic signed [COORD_BITS-1:0] i_seg_a_start_y,
    input  logic signed [COORD_BITS-1:0] i_seg_a_start_z,
    input  logic signed [COORD_BITS-1:0] i_seg_a_end_x,
    input  logic signed [COORD_BITS-1:0] i_seg_a_end_y,
    input  logic signed [COORD_BITS-1:0] i_seg_a_end_z,
    input  logic signed [COORD_BITS-1:0] i_seg_b_start_x,
    input  logic signed [COORD_BITS-1:0] i_seg_b_start_y,
    input  logic signed [COORD_BITS-1:0] i_seg_b_start_z,
    input  logic signed [COORD_BITS-1:0] i_seg_b_end_x,
    input  logic signed [COORD_BITS-1:0] i_seg_b_end_y,
    input  logic signed [COORD_BITS-1:0] i_seg_b_end_z,
    output logic                         o_done,
    output logic [COORD_BITS:0]          o_closest_distance
);
    import ssd_pkg::*;

    localparam int VW = COORD_BITS + 1;
    localparam int DW = 2 * VW + 2;
    localparam int NW = 2 * DW + 1;
    localparam int JW = 4 * NW + 9 * VW;

    logic                    accept;
    logic                    push;
    logic [JW-1:0]           job;
    t_q_stat                 q_stat;
    logic                    q_vld;
    logic [JW-1:0]           q_job;
    logic [12*COORD_BITS-1:0] coords;
    logic [7:0]              r_inflight;

    assign accept = start && !busy;

    // point order: A start, A end, B start, B end; x at the low end
    assign coords = {i_seg_b_end_z, i_seg_b_end_y, i_seg_b_end_x,
                     i_seg_b_start_z, i_seg_b_start_y, i_seg_b_start_x,
                     i_seg_a_end_z, i_seg_a_end_y, i_seg_a_end_x,
                     i_seg_a_start_z, i_seg_a_start_y, i_seg_a_start_x};

    // Front: difference vectors, dot products, determinant and the
    // clamp decisions, leaving numerator/denominator pairs for sc and tc.
    ssd_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_coords (coords),
        .i_q_stat (q_stat),
        .o_stall  (busy),
        .o_push   (push),
        .o_job    (job)
    );

    // Short queue between the classifier and the arithmetic back end.
    ssd_fifo #(.W(JW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job),
        .o_stat  (q_stat),
        .o_vld   (q_vld),
        .o_data  (q_job)
    );

    // Back: Q1.16 divisions, closest vector, squared length, square root.
    ssd_back #(.COORD_BITS(COORD_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (q_vld),
        .i_job   (q_job),
        .o_done  (o_done),
        .o_dist  (o_closest_distance)
    );

    // items accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + 8'(accept) - 8'(o_done);
        end
    end

    `SSD_ASSERT_NOW(a_done_has_item, i_clk, i_rst_n, o_done, r_inflight != '0, "result without item")
    `SSD_ASSERT_NOW(a_empty_not_busy, i_clk, i_rst_n, q_stat.empty, !busy, "busy with empty queue")
    `SSD_ASSERT_NEXT(a_accept_counted, i_clk, i_rst_n, accept && !o_done, r_inflight == $past(r_inflight) + 8'd1, "item not counted")

endmodule
